// ===== hw/rtl/fast_packet_framer_core_defines.svh =====
// Assertion macros for the fast packet framer.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef FAST_PACKET_FRAMER_CORE_DEFINES_SVH
`define FAST_PACKET_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication.
`define FPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/fpf_pkg.sv =====
// ----------------------------------------------------------------------------
// fpf_pkg
// Shared types and codes for the fast packet framer.
// ----------------------------------------------------------------------------
package fpf_pkg;

	localparam int FRAME_MAX   = 8;
	localparam int ID_W        = 29;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] OP_START_SINGLE  = 3'd0;
	localparam logic [2:0] OP_START_FAST    = 3'd1;
	localparam logic [2:0] OP_PAYLOAD       = 3'd2;
	localparam logic [2:0] OP_FINISH_SINGLE = 3'd3;
	localparam logic [2:0] OP_FINISH_FAST   = 3'd4;

	localparam logic [1:0] ST_SENT       = 2'd0;
	localparam logic [1:0] ST_DROPPED    = 2'd1;
	localparam logic [1:0] ST_WRONG_MODE = 2'd2;

	typedef logic [FRAME_MAX-1:0][7:0] store_t;

	typedef struct packed {
		logic [ID_W-1:0]        out_id;
		logic [FRAME_MAX*8-1:0] frame_bytes;
		logic [3:0]             frame_length;
		logic [1:0]             status;
	} res_t;

	typedef struct packed {
		logic full;
		logic avail;
	} qstat_t;

endpackage

// ===== hw/rtl/fpf_front.sv =====
// ----------------------------------------------------------------------------
// fpf_front
// Accepts items, keeps the packet state and builds at most one result each.
// ----------------------------------------------------------------------------
module fpf_front import fpf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic [2:0]      operation,
	input  logic [7:0]      payload_byte,
	input  logic [ID_W-1:0] frame_id,
	input  qstat_t          qstat,
	output logic            push,
	output res_t            push_data
);

	store_t          store_q, store_nx;
	logic [3:0]      count_q, count_nx;
	logic            fast_q, fast_nx;
	logic [2:0]      seq_q, seq_nx;
	logic [4:0]      idx_q, idx_nx;
	logic [ID_W-1:0] id_q, id_nx;
	logic            acc, emit;
	res_t            res;

	function automatic logic [FRAME_MAX*8-1:0] pack_frame(store_t s, logic [3:0] n);
		logic [FRAME_MAX*8-1:0] r;
		r = '0;
		for (int i = 0; i < FRAME_MAX; i++) begin
			if (4'(i) < n)
				r[i*8 +: 8] = s[i];
		end
		return r;
	endfunction

	assign item_stall = qstat.full;
	assign acc        = item_valid && !item_stall;

	always_comb begin
		store_nx = store_q;
		count_nx = count_q;
		fast_nx  = fast_q;
		seq_nx   = seq_q;
		idx_nx   = idx_q;
		id_nx    = id_q;
		emit     = 1'b0;
		res      = '{out_id: id_q, frame_bytes: '0, frame_length: 4'd0, status: ST_SENT};
		unique case (operation)
			OP_START_SINGLE: begin
				id_nx    = frame_id;
				count_nx = 4'd0;
				fast_nx  = 1'b0;
			end
			OP_START_FAST: begin
				id_nx       = frame_id;
				fast_nx     = 1'b1;
				seq_nx      = seq_q + 3'd1;
				store_nx[0] = {seq_q + 3'd1, 5'd0};
				store_nx[1] = payload_byte;
				idx_nx      = 5'd1;
				count_nx    = 4'd2;
			end
			OP_PAYLOAD: begin
				if (count_q < 4'(FRAME_MAX)) begin
					store_nx[count_q[2:0]] = payload_byte;
					count_nx = count_q + 4'd1;
					if (fast_q && count_q == 4'(FRAME_MAX - 1)) begin
						emit             = 1'b1;
						res.frame_bytes  = pack_frame(store_nx, 4'(FRAME_MAX));
						res.frame_length = 4'(FRAME_MAX);
						store_nx[0]      = {seq_q, idx_q};
						idx_nx           = idx_q + 5'd1;
						count_nx         = 4'd1;
					end
				end else begin
					emit       = 1'b1;
					res.status = ST_DROPPED;
				end
			end
			OP_FINISH_SINGLE: begin
				if (!fast_q) begin
					if (count_q != 4'd0) begin
						emit             = 1'b1;
						res.frame_bytes  = pack_frame(store_q, count_q);
						res.frame_length = count_q;
					end
				end else begin
					emit       = 1'b1;
					res.status = ST_WRONG_MODE;
				end
			end
			OP_FINISH_FAST: begin
				if (fast_q) begin
					if (count_q > 4'd1) begin
						emit             = 1'b1;
						res.frame_bytes  = pack_frame(store_q, count_q);
						res.frame_length = count_q;
					end
				end else begin
					emit       = 1'b1;
					res.status = ST_WRONG_MODE;
				end
			end
			default: begin
			end
		endcase
	end

	assign push      = acc && emit;
	assign push_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
			fast_q  <= 1'b0;
			seq_q   <= 3'd0;
			idx_q   <= 5'd0;
			id_q    <= '0;
		end else if (acc) begin
			count_q <= count_nx;
			fast_q  <= fast_nx;
			seq_q   <= seq_nx;
			idx_q   <= idx_nx;
			id_q    <= id_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			store_q <= store_nx;
	end

endmodule

// ===== hw/rtl/fpf_queue.sv =====
// ----------------------------------------------------------------------------
// fpf_queue
// Small result queue between the front and the back.
// ----------------------------------------------------------------------------
module fpf_queue import fpf_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  res_t   push_data,
	input  logic   pop,
	output res_t   head,
	output qstat_t qstat
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	res_t          mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign qstat.full  = (cnt_q == CW'(Depth));
	assign qstat.avail = (cnt_q != '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && qstat.avail;
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop)
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// ===== hw/rtl/fpf_back.sv =====
// ----------------------------------------------------------------------------
// fpf_back
// Output register: drains the queue onto the frame channel.
// ----------------------------------------------------------------------------
module fpf_back import fpf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  qstat_t                 qstat,
	input  res_t                   head,
	output logic                   pop,
	output logic                   frame_valid,
	input  logic                   frame_stall,
	output logic [ID_W-1:0]        out_id,
	output logic [FRAME_MAX*8-1:0] frame_bytes,
	output logic [3:0]             frame_length,
	output logic [1:0]             status
);

	logic valid_q;
	res_t res_q;

	assign pop = qstat.avail && (!valid_q || !frame_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!frame_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= head;
	end

	assign frame_valid  = valid_q;
	assign out_id       = res_q.out_id;
	assign frame_bytes  = res_q.frame_bytes;
	assign frame_length = res_q.frame_length;
	assign status       = res_q.status;

endmodule

// ===== hw/rtl/fast_packet_framer_core.sv =====
// ----------------------------------------------------------------------------
// fast_packet_framer_core
// Packs payload bytes into CAN frames, single or fast-packet framing.
// ----------------------------------------------------------------------------
// Channel | Signals                                        | Dir
// item    | item_valid, item_stall, operation,             | in
//         | payload_byte, frame_id                         |
// frame   | frame_valid, frame_stall, out_id, frame_bytes, | out
//         | frame_length, status                           |
//
// One item per cycle while item_stall is low; each item updates the packet
// state when taken. Results pass the result queue, then the output register.
// Reset clears packet state, queue and output valid; frame bytes are unset.
// item_stall rises only when the result queue is full, i.e. when frame_stall
// has held the output register for QueueDepth results.
// ----------------------------------------------------------------------------
module fast_packet_framer_core import fpf_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [2:0]             operation,
	input  logic [7:0]             payload_byte,
	input  logic [ID_W-1:0]        frame_id,
	output logic                   frame_valid,
	input  logic                   frame_stall,
	output logic [ID_W-1:0]        out_id,
	output logic [FRAME_MAX*8-1:0] frame_bytes,
	output logic [3:0]             frame_length,
	output logic [1:0]             status
);

	qstat_t qstat;
	logic   push, pop;
	res_t   push_data, head;

	fpf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.payload_byte (payload_byte),
		.frame_id     (frame_id),
		.qstat        (qstat),
		.push         (push),
		.push_data    (push_data)
	);

	fpf_queue #(.Depth(QueueDepth)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	fpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.head         (head),
		.pop          (pop),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.out_id       (out_id),
		.frame_bytes  (frame_bytes),
		.frame_length (frame_length),
		.status       (status)
	);

endmodule

// ===== hw/rtl/fpf_checker.sv =====
// ----------------------------------------------------------------------------
// fpf_checker
// Port-level checks on the framer's frame channel.
// ----------------------------------------------------------------------------
`include "fast_packet_framer_core_defines.svh"

module fpf_checker import fpf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   frame_valid,
	input logic                   frame_stall,
	input logic [ID_W-1:0]        out_id,
	input logic [FRAME_MAX*8-1:0] frame_bytes,
	input logic [3:0]             frame_length,
	input logic [1:0]             status
);

	`FPF_ASSERT_NEXT(a_frame_hold, frame_valid && frame_stall, frame_valid && $stable(out_id) && $stable(frame_bytes) && $stable(frame_length) && $stable(status), "stalled frame transaction changed")

	`FPF_ASSERT_IMP(a_flag_empty, frame_valid && status != ST_SENT, frame_length == 4'd0 && frame_bytes == '0, "flagged transaction carries data")

	`FPF_ASSERT_IMP(a_sent_len, frame_valid && status == ST_SENT, frame_length != 4'd0 && frame_length <= 4'(FRAME_MAX), "sent frame length out of range")

	`FPF_ASSERT_IMP(a_status_code, frame_valid, status == ST_SENT || status == ST_DROPPED || status == ST_WRONG_MODE, "unknown status code")

endmodule

bind fast_packet_framer_core fpf_checker u_fpf_checker (.*);

// ===== tb/tb_fast_packet_framer_core.sv =====
// ----------------------------------------------------------------------------
// tb_fast_packet_framer_core
// Self-checking bench for the fast packet framer. A queue of items feeds a
// clocked driver; accepted items are run through a local copy of the framing
// rules and the frames they should produce are matched, field by field and
// in order, against the frame channel. Three idling phases are run.
// ----------------------------------------------------------------------------
module tb_fast_packet_framer_core;
	import fpf_pkg::*;

	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int unsigned PHASE_ITEMS = 217;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [2:0]      op;
		logic [7:0]      data;
		logic [ID_W-1:0] id;
	} item_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic [2:0]             operation = '0;
	logic [7:0]             payload_byte = '0;
	logic [ID_W-1:0]        frame_id = '0;
	logic                   frame_valid;
	logic                   frame_stall = 1'b0;
	logic [ID_W-1:0]        out_id;
	logic [FRAME_MAX*8-1:0] frame_bytes;
	logic [3:0]             frame_length;
	logic [1:0]             status;

	item_t       item_backlog[$];
	res_t        frames_due[$];
	item_t       next_item;
	logic        item_taken = 1'b0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned items_queued = 0;
	int unsigned fault_count = 0;
	int unsigned quiet_cycles = 0;

	// framer state as the bench sees it
	store_t          pred_store = '0;
	logic [3:0]      pred_count = '0;
	logic            pred_fast = 1'b0;
	logic [2:0]      pred_seq = '0;
	logic [4:0]      pred_index = '0;
	logic [ID_W-1:0] pred_id = '0;

	fast_packet_framer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.payload_byte (payload_byte),
		.frame_id     (frame_id),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.out_id       (out_id),
		.frame_bytes  (frame_bytes),
		.frame_length (frame_length),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ID_W-1:0] rand_id();
		case ($urandom_range(9))
			0: rand_id = '0;
			1: rand_id = '1;
			default: rand_id = ID_W'($urandom);
		endcase
	endfunction

	function automatic res_t build_frame(logic [1:0] st, bit with_data);
		res_t f;
		f = '0;
		f.out_id = pred_id;
		f.status = st;
		if (with_data) begin
			f.frame_length = pred_count;
			for (int i = 0; i < FRAME_MAX; i++) begin
				if (i < pred_count)
					f.frame_bytes[i*8 +: 8] = pred_store[i];
			end
		end
		return f;
	endfunction

	task automatic track_framer(item_t it);
		case (it.op)
			OP_START_SINGLE: begin
				pred_id = it.id;
				pred_count = '0;
				pred_fast = 1'b0;
			end
			OP_START_FAST: begin
				pred_id = it.id;
				pred_fast = 1'b1;
				pred_seq = pred_seq + 3'd1;
				pred_store[0] = {pred_seq, 5'd0};
				pred_index = 5'd1;
				pred_store[1] = it.data;
				pred_count = 4'd2;
			end
			OP_PAYLOAD: begin
				if (pred_count < FRAME_MAX) begin
					pred_store[pred_count[2:0]] = it.data;
					pred_count = pred_count + 4'd1;
					if (pred_fast && pred_count == FRAME_MAX) begin
						frames_due.push_back(build_frame(ST_SENT, 1'b1));
						pred_store[0] = {pred_seq, pred_index};
						pred_index = pred_index + 5'd1;
						pred_count = 4'd1;
					end
				end else begin
					frames_due.push_back(build_frame(ST_DROPPED, 1'b0));
				end
			end
			OP_FINISH_SINGLE: begin
				if (pred_fast)
					frames_due.push_back(build_frame(ST_WRONG_MODE, 1'b0));
				else if (pred_count > 0)
					frames_due.push_back(build_frame(ST_SENT, 1'b1));
			end
			OP_FINISH_FAST: begin
				if (!pred_fast)
					frames_due.push_back(build_frame(ST_WRONG_MODE, 1'b0));
				else if (pred_count > 1)
					frames_due.push_back(build_frame(ST_SENT, 1'b1));
			end
			default: ;
		endcase
	endtask

	task automatic push_item(logic [2:0] op, logic [7:0] data, logic [ID_W-1:0] id);
		item_backlog.push_back('{op: op, data: data, id: id});
		items_queued++;
	endtask

	// start, n bytes, then mostly the matching finish, now and then the
	// other one, now and then twice
	task automatic queue_packet(logic [2:0] start_op, logic [2:0] good_fin,
			logic [2:0] bad_fin, int unsigned n);
		logic [2:0] fin;
		push_item(start_op, 8'($urandom), rand_id());
		repeat (n) push_item(OP_PAYLOAD, 8'($urandom), rand_id());
		fin = ($urandom_range(9) == 0) ? bad_fin : good_fin;
		repeat (($urandom_range(9) == 0) ? 2 : 1) push_item(fin, 8'($urandom), rand_id());
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (item_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_item = item_backlog.pop_front();
					item_valid <= 1'b1;
					operation <= next_item.op;
					payload_byte <= next_item.data;
					frame_id <= next_item.id;
				end else begin
					item_valid <= 1'b0;
				end
			end
			frame_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			item_taken <= item_valid && !item_stall;
			if (item_valid && !item_stall)
				track_framer('{op: operation, data: payload_byte, id: frame_id});
			if (frame_valid && !frame_stall) begin
				if (frames_due.size() == 0) begin
					$error("frame with no transaction pending: id %h len %0d status %0d",
						out_id, frame_length, status);
					fault_count++;
				end else begin
					want = frames_due.pop_front();
					if (out_id !== want.out_id) begin
						$error("out_id: expected %h, got %h", want.out_id, out_id);
						fault_count++;
					end
					if (frame_bytes !== want.frame_bytes) begin
						$error("frame_bytes: expected %h, got %h", want.frame_bytes, frame_bytes);
						fault_count++;
					end
					if (frame_length !== want.frame_length) begin
						$error("frame_length: expected %0d, got %0d",
							want.frame_length, frame_length);
						fault_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fault_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (frame_valid && !frame_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned phase_start;
		int unsigned r;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 3; p++) begin
			tx_idle_pct = (p == 0) ? 12 : (p == 1) ? 78 : 0;
			rx_idle_pct = (p == 0) ? 78 : (p == 1) ? 12 : 0;
			phase_start = items_queued;
			if (p == 0) begin
				// a byte ahead of any start, then a bare single finish
				push_item(OP_PAYLOAD, 8'hA5, '1);
				push_item(OP_FINISH_SINGLE, 8'h00, '0);
				// full single frame, one byte too many, finish twice
				push_item(OP_START_SINGLE, 8'h00, '1);
				for (int i = 0; i < FRAME_MAX; i++)
					push_item(OP_PAYLOAD, (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom),
						rand_id());
				push_item(OP_PAYLOAD, 8'h5A, '0);
				push_item(OP_FINISH_SINGLE, 8'hFF, '0);
				push_item(OP_FINISH_SINGLE, 8'h00, '1);
				// empty single packet
				push_item(OP_START_SINGLE, 8'hFF, '0);
				push_item(OP_FINISH_SINGLE, 8'h00, '0);
				// fast: early flush, fill a frame, empty flush, wrong-mode finish
				push_item(OP_START_FAST, 8'hFF, '1);
				push_item(OP_FINISH_FAST, 8'h00, '0);
				repeat (6) push_item(OP_PAYLOAD, 8'($urandom), rand_id());
				push_item(OP_FINISH_FAST, 8'h00, '0);
				push_item(OP_FINISH_SINGLE, 8'h00, '0);
				push_item(OP_FINISH_FAST, 8'h00, '0);
				push_item(OP_SPARE_5, 8'hFF, '1);
				push_item(OP_SPARE_6, 8'h00, '0);
				push_item(OP_SPARE_7, 8'hFF, '1);
				// long enough for the frame index to wrap
				queue_packet(OP_START_FAST, OP_FINISH_FAST, OP_FINISH_SINGLE,
					$urandom_range(224, 240));
			end
			while (items_queued - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 40)
					queue_packet(OP_START_SINGLE, OP_FINISH_SINGLE, OP_FINISH_FAST,
						($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(9, 11));
				else if (r < 85)
					queue_packet(OP_START_FAST, OP_FINISH_FAST, OP_FINISH_SINGLE,
						($urandom_range(14) == 0) ? $urandom_range(224, 240)
							: $urandom_range(30));
				else
					push_item(3'($urandom_range(7)), 8'($urandom), rand_id());
			end
			do @(posedge clk);
			while (!(item_backlog.size() == 0 && !item_valid && frames_due.size() == 0));
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (frames_due.size() != 0) begin
			$error("%0d frames never arrived", frames_due.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fpf_pkg.sv
hw/rtl/fpf_front.sv
hw/rtl/fpf_queue.sv
hw/rtl/fpf_back.sv
hw/rtl/fast_packet_framer_core.sv
hw/rtl/fpf_checker.sv
tb/tb_fast_packet_framer_core.sv
